[design/axis_to_rotation_quaternion_unit_macros.svh]
// Assertion helpers for the rotation quaternion unit.
`ifndef AXIS_TO_ROTATION_QUATERNION_UNIT_MACROS_SVH
`define AXIS_TO_ROTATION_QUATERNION_UNIT_MACROS_SVH

// Same-cycle implication, checked on aclk, off during reset.
`define ARQU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("arqu check failed");

// Next-cycle implication, checked on aclk, off during reset.
`define ARQU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("arqu check failed");

`endif

[design/arqu_pkg.sv]
package arqu_pkg;

    localparam int IN_WIDTH      = 16;
    localparam int OUT_WIDTH     = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int MAG_W         = IN_WIDTH;
    localparam int NORM_TOP      = 30;
    localparam int NRM_W         = NORM_TOP + 1;
    localparam int WIDE_W        = MAG_W + NORM_TOP + 1;
    localparam int SHIFT_W       = 5;
    localparam int SQ_W          = 2 * NRM_W;
    localparam int SQRT_STEPS    = 32;
    localparam int DIV_STEPS     = 33;
    localparam int W_SHIFT       = 30 - OUT_FRAC_BITS;
    localparam int P_SHIFT       = 60 - OUT_FRAC_BITS;
    // input, normalize, square, sum, root, ratio setup, divide, clamp, root, scale, round
    localparam int LAT           = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1 + SQRT_STEPS + 2;

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [31:0] d;
        logic [31:0] rem;
        logic [32:0] low;
        logic [32:0] q;
    } div_t;

    typedef struct packed {
        logic nx;
        logic ny;
        logic nz;
        logic deg;
        logic zero;
    } flag_t;

    typedef struct packed {
        flag_t            fl;
        logic [NRM_W-1:0] sz;
        logic [NRM_W-1:0] tx;
        logic [NRM_W-1:0] ty;
    } side_a_t;

    typedef struct packed {
        flag_t            fl;
        logic [NRM_W-1:0] ux;
        logic [NRM_W-1:0] uy;
    } side_c_t;

    // Shift that brings the top set bit of m up to bit NORM_TOP.
    function automatic logic [SHIFT_W-1:0] norm_shift(input logic [MAG_W-1:0] m);
        logic [SHIFT_W-1:0] k;
        k = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (m[i]) k = SHIFT_W'(NORM_TOP - i);
        end
        return k;
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic [IN_WIDTH-1:0] raw);
        return raw[IN_WIDTH-1] ? MAG_W'(~raw + 1'b1) : MAG_W'(raw);
    endfunction

endpackage

[design/axis_to_rotation_quaternion_unit.sv]
// Throughput: one item per cycle; the pipeline of root and divider cells moves as one.
// The whole pipeline holds while a finished result is not taken.
// Reset: aresetn, synchronous, active low, clears the stage valid bits only.
`include "axis_to_rotation_quaternion_unit_macros.svh"
module axis_to_rotation_quaternion_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // dir_x [15:0], dir_y [31:16], dir_z [47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // quat_w [15:0], quat_x [31:16], quat_y [47:32],
                                        // quat_z [63:48]
    output logic        m_axis_tuser    // axis_degenerate [0]
);
    import arqu_pkg::*;

    // Advance every stage whenever the output register is free or being read.
    logic en;
    logic [LAT-1:0] vld_reg;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // Stage 1: split sign and magnitude, flag the undefined axis.
    logic [MAG_W-1:0] ax_reg, ay_reg, az_reg;
    flag_t            fl1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg       <= mag_of(s_axis_tdata[15:0]);
            ay_reg       <= mag_of(s_axis_tdata[31:16]);
            az_reg       <= mag_of(s_axis_tdata[47:32]);
            fl1_reg.nx   <= s_axis_tdata[15];
            fl1_reg.ny   <= s_axis_tdata[31];
            fl1_reg.nz   <= s_axis_tdata[47];
            fl1_reg.deg  <= (s_axis_tdata[31:0] == 32'd0);
            fl1_reg.zero <= (s_axis_tdata[47:0] == 48'd0);
        end
    end

    // Stage 2: normalize all three by one shift, and x, y by a shift of their own.
    logic [MAG_W-1:0]   m2, m3;
    logic [SHIFT_W-1:0] k2, k3;
    logic [NRM_W-1:0]   sx2_reg, sy2_reg;
    side_a_t            sa2_reg;

    always_comb begin
        m2 = (ax_reg > ay_reg) ? ax_reg : ay_reg;
        m3 = (az_reg > m2) ? az_reg : m2;
        k2 = norm_shift(m2);
        k3 = norm_shift(m3);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx2_reg    <= NRM_W'(WIDE_W'(ax_reg) << k3);
            sy2_reg    <= NRM_W'(WIDE_W'(ay_reg) << k3);
            sa2_reg.sz <= NRM_W'(WIDE_W'(az_reg) << k3);
            sa2_reg.tx <= NRM_W'(WIDE_W'(ax_reg) << k2);
            sa2_reg.ty <= NRM_W'(WIDE_W'(ay_reg) << k2);
            sa2_reg.fl <= fl1_reg;
        end
    end

    // Stage 3: squares.
    logic [SQ_W-1:0] px3_reg, py3_reg, pz3_reg, rx3_reg, ry3_reg;
    side_a_t         sa3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            px3_reg <= sx2_reg * sx2_reg;
            py3_reg <= sy2_reg * sy2_reg;
            pz3_reg <= sa2_reg.sz * sa2_reg.sz;
            rx3_reg <= sa2_reg.tx * sa2_reg.tx;
            ry3_reg <= sa2_reg.ty * sa2_reg.ty;
            sa3_reg <= sa2_reg;
        end
    end

    // Stage 4: sums of squares feed the two root chains.
    sqrt_t   sqn_init_reg, sqr_init_reg;
    side_a_t sa4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sqn_init_reg.rad  <= 64'(px3_reg) + 64'(py3_reg) + 64'(pz3_reg);
            sqn_init_reg.rem  <= '0;
            sqn_init_reg.root <= '0;
            sqr_init_reg.rad  <= 64'(rx3_reg) + 64'(ry3_reg);
            sqr_init_reg.rem  <= '0;
            sqr_init_reg.root <= '0;
            sa4_reg           <= sa3_reg;
        end
    end

    // Root chains for the vector length n and the axis length r.
    sqrt_t   sqn [SQRT_STEPS+1];
    sqrt_t   sqr [SQRT_STEPS+1];
    side_a_t line_a_reg [SQRT_STEPS];

    assign sqn[0] = sqn_init_reg;
    assign sqr[0] = sqr_init_reg;

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_root_a
        arqu_sqrt_cell u_n (.aclk(aclk), .en(en), .d_in(sqn[j]), .d_out(sqn[j+1]));
        arqu_sqrt_cell u_r (.aclk(aclk), .en(en), .d_in(sqr[j]), .d_out(sqr[j+1]));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            line_a_reg[0] <= sa4_reg;
            for (int i = 1; i < SQRT_STEPS; i++) line_a_reg[i] <= line_a_reg[i-1];
        end
    end

    // Stage 5: set up (n +- z)/n and the axis ratios x/r, y/r.
    side_a_t     sa5;
    logic [31:0] n5, r5, szc;
    logic [32:0] up5, dn5, numh, numg;
    logic [63:0] dvd_h, dvd_g, dvd_x, dvd_y;
    div_t        dvh_init_reg, dvg_init_reg, dvx_init_reg, dvy_init_reg;
    flag_t       fl5_reg;

    always_comb begin
        sa5   = line_a_reg[SQRT_STEPS-1];
        n5    = sqn[SQRT_STEPS].root;
        r5    = sqr[SQRT_STEPS].root;
        szc   = (32'(sa5.sz) > n5) ? n5 : 32'(sa5.sz);
        up5   = 33'(n5) + 33'(szc);
        dn5   = 33'(n5 - szc);
        numh  = sa5.fl.nz ? dn5 : up5;
        numg  = sa5.fl.nz ? up5 : dn5;
        dvd_h = 64'(numh) << 31;
        dvd_g = 64'(numg) << 31;
        dvd_x = 64'(sa5.tx) << 30;
        dvd_y = 64'(sa5.ty) << 30;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dvh_init_reg <= '{d: n5, rem: 32'(dvd_h[63:33]), low: dvd_h[32:0], q: '0};
            dvg_init_reg <= '{d: n5, rem: 32'(dvd_g[63:33]), low: dvd_g[32:0], q: '0};
            dvx_init_reg <= '{d: r5, rem: 32'(dvd_x[63:33]), low: dvd_x[32:0], q: '0};
            dvy_init_reg <= '{d: r5, rem: 32'(dvd_y[63:33]), low: dvd_y[32:0], q: '0};
            fl5_reg      <= sa5.fl;
        end
    end

    // Divider chains.
    div_t  dvh [DIV_STEPS+1];
    div_t  dvg [DIV_STEPS+1];
    div_t  dvx [DIV_STEPS+1];
    div_t  dvy [DIV_STEPS+1];
    flag_t line_b_reg [DIV_STEPS];

    assign dvh[0] = dvh_init_reg;
    assign dvg[0] = dvg_init_reg;
    assign dvx[0] = dvx_init_reg;
    assign dvy[0] = dvy_init_reg;

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        arqu_div_cell u_h (.aclk(aclk), .en(en), .d_in(dvh[j]), .d_out(dvh[j+1]));
        arqu_div_cell u_g (.aclk(aclk), .en(en), .d_in(dvg[j]), .d_out(dvg[j+1]));
        arqu_div_cell u_x (.aclk(aclk), .en(en), .d_in(dvx[j]), .d_out(dvx[j+1]));
        arqu_div_cell u_y (.aclk(aclk), .en(en), .d_in(dvy[j]), .d_out(dvy[j+1]));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            line_b_reg[0] <= fl5_reg;
            for (int i = 1; i < DIV_STEPS; i++) line_b_reg[i] <= line_b_reg[i-1];
        end
    end

    // Stage 6: clamp the ratios; a zero vector takes c = 0 (both halves one half).
    localparam logic [32:0] H_MAX  = 33'(1) << 32;
    localparam logic [32:0] H_HALF = 33'(1) << 31;
    localparam logic [32:0] U_MAX  = 33'(1) << 30;

    flag_t       fl6;
    logic [32:0] h6, g6, ux6, uy6;
    sqrt_t       sqw_init_reg, sqs_init_reg;
    side_c_t     sc6_reg;

    always_comb begin
        fl6 = line_b_reg[DIV_STEPS-1];
        h6  = (dvh[DIV_STEPS].q > H_MAX) ? H_MAX : dvh[DIV_STEPS].q;
        g6  = (dvg[DIV_STEPS].q > H_MAX) ? H_MAX : dvg[DIV_STEPS].q;
        ux6 = (dvx[DIV_STEPS].q > U_MAX) ? U_MAX : dvx[DIV_STEPS].q;
        uy6 = (dvy[DIV_STEPS].q > U_MAX) ? U_MAX : dvy[DIV_STEPS].q;
        if (fl6.zero) begin
            h6 = H_HALF;
            g6 = H_HALF;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqw_init_reg <= '{rad: 64'(h6) << 28, rem: '0, root: '0};
            sqs_init_reg <= '{rad: 64'(g6) << 28, rem: '0, root: '0};
            sc6_reg.fl   <= fl6;
            sc6_reg.ux   <= ux6[NRM_W-1:0];
            sc6_reg.uy   <= uy6[NRM_W-1:0];
        end
    end

    // Root chains for cos and sin of the half angle.
    sqrt_t   sqw [SQRT_STEPS+1];
    sqrt_t   sqs [SQRT_STEPS+1];
    side_c_t line_c_reg [SQRT_STEPS];

    assign sqw[0] = sqw_init_reg;
    assign sqs[0] = sqs_init_reg;

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_root_b
        arqu_sqrt_cell u_w (.aclk(aclk), .en(en), .d_in(sqw[j]), .d_out(sqw[j+1]));
        arqu_sqrt_cell u_s (.aclk(aclk), .en(en), .d_in(sqs[j]), .d_out(sqs[j+1]));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            line_c_reg[0] <= sc6_reg;
            for (int i = 1; i < SQRT_STEPS; i++) line_c_reg[i] <= line_c_reg[i-1];
        end
    end

    // Stage 7: scale the unit axis by the half-angle sine.
    side_c_t          sc7;
    logic [NRM_W-1:0] sq7;
    logic [NRM_W-1:0] wq7_reg;
    logic [SQ_W-1:0]  pqy7_reg, pqx7_reg;
    flag_t            fl7_reg;

    always_comb begin
        sc7 = line_c_reg[SQRT_STEPS-1];
        sq7 = sqs[SQRT_STEPS].root[NRM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wq7_reg  <= sqw[SQRT_STEPS].root[NRM_W-1:0];
            pqy7_reg <= sc7.ux * sq7;
            pqx7_reg <= sc7.uy * sq7;
            fl7_reg  <= sc7.fl;
        end
    end

    // Stage 8: round to the output format, apply signs, drop the axis when undefined.
    localparam logic [NRM_W:0] W_HALF = (NRM_W+1)'(1) << (W_SHIFT - 1);
    localparam logic [SQ_W:0]  P_HALF = (SQ_W+1)'(1) << (P_SHIFT - 1);

    logic [NRM_W:0]     w_sum;
    logic [SQ_W:0]      y_sum, x_sum;
    logic [OUT_WIDTH-1:0] w8, ymag, xmag, qy8, qx8;
    logic [63:0]        out_data_reg;
    logic               out_deg_reg;

    always_comb begin
        w_sum = (NRM_W+1)'(wq7_reg) + W_HALF;
        y_sum = (SQ_W+1)'(pqy7_reg) + P_HALF;
        x_sum = (SQ_W+1)'(pqx7_reg) + P_HALF;
        w8    = OUT_WIDTH'(w_sum >> W_SHIFT);
        ymag  = fl7_reg.deg ? '0 : OUT_WIDTH'(y_sum >> P_SHIFT);
        xmag  = fl7_reg.deg ? '0 : OUT_WIDTH'(x_sum >> P_SHIFT);
        qy8   = fl7_reg.nx ? OUT_WIDTH'(~ymag + 1'b1) : ymag;
        qx8   = fl7_reg.ny ? xmag : OUT_WIDTH'(~xmag + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {{OUT_WIDTH{1'b0}}, qy8, qx8, w8};
            out_deg_reg  <= fl7_reg.deg;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_deg_reg;

    // An undefined axis leaves the vector part zero.
    `ARQU_ASSERT_NOW(a_deg_axis_zero, m_axis_tvalid && m_axis_tuser,
        (m_axis_tdata[31:16] == 16'd0) && (m_axis_tdata[47:32] == 16'd0))
    // The scalar part is a root and never negative.
    `ARQU_ASSERT_NOW(a_w_nonneg, m_axis_tvalid, !m_axis_tdata[15])
    // An accepted item enters the first stage.
    `ARQU_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_reg[0])

endmodule

[design/arqu_sqrt_cell.sv]
module arqu_sqrt_cell (
    input  logic          aclk,
    input  logic          en,
    input  arqu_pkg::sqrt_t d_in,
    output arqu_pkg::sqrt_t d_out
);
    import arqu_pkg::*;

    logic [35:0] cur;
    logic [35:0] trial;
    sqrt_t       d_next;

    // One root bit per cell: bring down two radicand bits, try a one.
    always_comb begin
        cur          = {d_in.rem, d_in.rad[63:62]};
        trial        = {2'b00, d_in.root, 2'b01};
        d_next.rad   = {d_in.rad[61:0], 2'b00};
        if (cur >= trial) begin
            d_next.rem  = 34'(cur - trial);
            d_next.root = {d_in.root[30:0], 1'b1};
        end else begin
            d_next.rem  = cur[33:0];
            d_next.root = {d_in.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) d_out <= d_next;
    end

endmodule

[design/arqu_div_cell.sv]
module arqu_div_cell (
    input  logic         aclk,
    input  logic         en,
    input  arqu_pkg::div_t d_in,
    output arqu_pkg::div_t d_out
);
    import arqu_pkg::*;

    logic [32:0] cur;
    div_t        d_next;

    // One quotient bit per cell: bring down a dividend bit, subtract if it fits.
    always_comb begin
        cur        = {d_in.rem, d_in.low[32]};
        d_next.d   = d_in.d;
        d_next.low = {d_in.low[31:0], 1'b0};
        if (cur >= {1'b0, d_in.d}) begin
            d_next.rem = 32'(cur - {1'b0, d_in.d});
            d_next.q   = {d_in.q[31:0], 1'b1};
        end else begin
            d_next.rem = cur[31:0];
            d_next.q   = {d_in.q[31:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) d_out <= d_next;
    end

endmodule
